FILE: hw/rtl/logbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// logbl_pkg
// Shared constants, types and codes of the log grid bilinear lookup.
// ----------------------------------------------------------------------------
package logbl_pkg;

    // grid size and table geometry
    localparam int RHO_POINTS  = 32;
    localparam int TEMP_POINTS = 32;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int DATA_W      = 16;
    localparam int FRAC_BITS   = 10;

    // index widths follow the grid size
    localparam int RHO_IDX_W  = (RHO_POINTS  > 1) ? $clog2(RHO_POINTS)  : 1;
    localparam int TEMP_IDX_W = (TEMP_POINTS > 1) ? $clog2(TEMP_POINTS) : 1;

    // grid origins and temperature step, in Q.10
    localparam int RHO_OFFSET  = 16 * 1024;
    localparam int TEMP_OFFSET = 18 * 1024;
    localparam int TEMP_SCALE  = 10;

    // opcodes of an input item
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } opcode_t;

    typedef logic [RHO_IDX_W-1:0]  rho_idx_t;
    typedef logic [TEMP_IDX_W-1:0] temp_idx_t;
    typedef logic [FRAC_BITS-1:0]  frac_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // grid stage result handed to the table and the blend stages
    typedef struct packed {
        logic      valid;
        opcode_t   op;
        rho_idx_t  r;
        rho_idx_t  r1;
        temp_idx_t t;
        temp_idx_t t1;
        frac_t     fr;
        frac_t     ft;
        addr_t     wr_addr;
        data_t     wr_data;
    } grid_t;

    // four corner values read from the table
    typedef struct packed {
        data_t v00;
        data_t v01;
        data_t v10;
        data_t v11;
    } corners_t;

endpackage

`default_nettype wire

FILE: hw/rtl/logbl_grid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// logbl_grid
// Grid stage: maps log density and log temperature to clamped indices and
// Q.10 fractions, and registers them with the write fields.
// ----------------------------------------------------------------------------
module logbl_grid (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logbl_pkg::opcode_t     in_op,
    input  wire logic signed [15:0]     in_log_density,
    input  wire logic signed [15:0]     in_log_temperature,
    input  wire logbl_pkg::addr_t       in_entry_address,
    input  wire logbl_pkg::data_t       in_entry_value,
    output logbl_pkg::grid_t            grid
);

    logbl_pkg::grid_t grid_reg;
    logbl_pkg::grid_t grid_next;

    logic signed [16:0] pos_d;
    logic signed [19:0] lt_ext;
    logic signed [19:0] pos_t;
    logic [31:0]        d_int;
    logic [31:0]        t_int;

    // grid positions in Q.10
    assign pos_d  = {in_log_density[15], in_log_density}
                    + 17'(logbl_pkg::RHO_OFFSET);
    assign lt_ext = {{4{in_log_temperature[15]}}, in_log_temperature};
    assign pos_t  = lt_ext * 20'(logbl_pkg::TEMP_SCALE)
                    - 20'(logbl_pkg::TEMP_OFFSET);
    assign d_int  = 32'(pos_d[16:logbl_pkg::FRAC_BITS]);
    assign t_int  = 32'(pos_t[19:logbl_pkg::FRAC_BITS]);

    // floor split with clamping at both edges
    always_comb
    begin
        grid_next.valid   = in_valid;
        grid_next.op      = in_op;
        grid_next.wr_addr = in_entry_address;
        grid_next.wr_data = in_entry_value;

        // density axis
        if (pos_d[16])
        begin
            grid_next.r  = '0;
            grid_next.fr = '0;
        end
        else if (d_int > 32'(logbl_pkg::RHO_POINTS - 1))
        begin
            grid_next.r  = logbl_pkg::rho_idx_t'(logbl_pkg::RHO_POINTS - 1);
            grid_next.fr = '0;
        end
        else
        begin
            grid_next.r  = d_int[logbl_pkg::RHO_IDX_W-1:0];
            grid_next.fr = pos_d[logbl_pkg::FRAC_BITS-1:0];
        end

        // temperature axis
        if (pos_t[19])
        begin
            grid_next.t  = '0;
            grid_next.ft = '0;
        end
        else if (t_int > 32'(logbl_pkg::TEMP_POINTS - 1))
        begin
            grid_next.t  = logbl_pkg::temp_idx_t'(logbl_pkg::TEMP_POINTS - 1);
            grid_next.ft = '0;
        end
        else
        begin
            grid_next.t  = t_int[logbl_pkg::TEMP_IDX_W-1:0];
            grid_next.ft = pos_t[logbl_pkg::FRAC_BITS-1:0];
        end

        // neighbors repeat at the last row or column
        if (32'(grid_next.r) < 32'(logbl_pkg::RHO_POINTS - 1))
            grid_next.r1 = grid_next.r + logbl_pkg::rho_idx_t'(1);
        else
            grid_next.r1 = grid_next.r;
        if (32'(grid_next.t) < 32'(logbl_pkg::TEMP_POINTS - 1))
            grid_next.t1 = grid_next.t + logbl_pkg::temp_idx_t'(1);
        else
            grid_next.t1 = grid_next.t;
    end

    // stage register, cleared as a whole at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grid_reg <= '0;
        else
            grid_reg <= grid_next;
    end

    assign grid = grid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/logbl_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// logbl_table
// Opacity table held in four identical copies, one per corner, so that a
// lookup reads all four corners at once. Writes go to every copy.
// ----------------------------------------------------------------------------
module logbl_table (
    input  wire logic                clk,
    input  wire logbl_pkg::grid_t    grid,
    output logbl_pkg::corners_t      corners
);

    logbl_pkg::data_t mem_00 [logbl_pkg::TABLE_DEPTH];
    logbl_pkg::data_t mem_01 [logbl_pkg::TABLE_DEPTH];
    logbl_pkg::data_t mem_10 [logbl_pkg::TABLE_DEPTH];
    logbl_pkg::data_t mem_11 [logbl_pkg::TABLE_DEPTH];

    logbl_pkg::data_t v00_reg;
    logbl_pkg::data_t v01_reg;
    logbl_pkg::data_t v10_reg;
    logbl_pkg::data_t v11_reg;

    logic [31:0]      row_t;
    logic [31:0]      row_t1;
    logbl_pkg::addr_t addr_00;
    logbl_pkg::addr_t addr_01;
    logbl_pkg::addr_t addr_10;
    logbl_pkg::addr_t addr_11;
    logic             wr_en;
    logic [31:0]      sum_00;
    logic [31:0]      sum_01;
    logic [31:0]      sum_10;
    logic [31:0]      sum_11;

    // corner addresses, wrapping modulo the table depth
    assign row_t   = 32'(grid.t)  * 32'(logbl_pkg::RHO_POINTS);
    assign row_t1  = 32'(grid.t1) * 32'(logbl_pkg::RHO_POINTS);
    assign sum_00  = row_t  + 32'(grid.r);
    assign sum_01  = row_t  + 32'(grid.r1);
    assign sum_10  = row_t1 + 32'(grid.r);
    assign sum_11  = row_t1 + 32'(grid.r1);
    assign addr_00 = sum_00[logbl_pkg::ADDR_W-1:0];
    assign addr_01 = sum_01[logbl_pkg::ADDR_W-1:0];
    assign addr_10 = sum_10[logbl_pkg::ADDR_W-1:0];
    assign addr_11 = sum_11[logbl_pkg::ADDR_W-1:0];

    assign wr_en = grid.valid && (grid.op == logbl_pkg::OP_WRITE);

    // copy for the low row, low column
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_00[grid.wr_addr] <= grid.wr_data;
        v00_reg <= mem_00[addr_00];
    end

    // copy for the low row, high column
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_01[grid.wr_addr] <= grid.wr_data;
        v01_reg <= mem_01[addr_01];
    end

    // copy for the high row, low column
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_10[grid.wr_addr] <= grid.wr_data;
        v10_reg <= mem_10[addr_10];
    end

    // copy for the high row, high column
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_11[grid.wr_addr] <= grid.wr_data;
        v11_reg <= mem_11[addr_11];
    end

    assign corners = '{v00: v00_reg, v01: v01_reg, v10: v10_reg, v11: v11_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/logbl_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// logbl_blend
// Two blend stages: rows along density, then the two rows along
// temperature, rounding half up and saturating to 16 bits.
// ----------------------------------------------------------------------------
module logbl_blend (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logbl_pkg::frac_t      in_fr,
    input  wire logbl_pkg::frac_t      in_ft,
    input  wire logbl_pkg::corners_t   corners,
    output logic                       out_valid,
    output logbl_pkg::data_t           out_value
);

    logic signed [16:0] d_lo;
    logic signed [16:0] d_hi;
    logic signed [10:0] fr_s;
    logic signed [27:0] lo_next;
    logic signed [27:0] hi_next;
    logic signed [27:0] lo_reg;
    logic signed [27:0] hi_reg;
    logbl_pkg::frac_t   ft_reg;
    logic               row_valid_reg;

    logic signed [28:0] d_row;
    logic signed [10:0] ft_s;
    logic signed [39:0] sum;
    logic signed [19:0] q;
    logbl_pkg::data_t   q_sat;
    logbl_pkg::data_t   value_reg;
    logic               done_reg;

    // row blends: v*1024 + f*(w - v)
    assign fr_s    = {1'b0, in_fr};
    assign d_lo    = {corners.v01[15], corners.v01} - {corners.v00[15], corners.v00};
    assign d_hi    = {corners.v11[15], corners.v11} - {corners.v10[15], corners.v10};
    assign lo_next = {{2{corners.v00[15]}}, corners.v00, 10'd0} + 28'(d_lo * fr_s);
    assign hi_next = {{2{corners.v10[15]}}, corners.v10, 10'd0} + 28'(d_hi * fr_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= 1'b0;
        else
            row_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        ft_reg <= in_ft;
    end

    // column blend with rounding offset at scale 2^20
    assign ft_s  = {1'b0, ft_reg};
    assign d_row = {hi_reg[27], hi_reg} - {lo_reg[27], lo_reg};
    assign sum   = {{2{lo_reg[27]}}, lo_reg, 10'd0}
                   + 40'(d_row * ft_s)
                   + 40'sd524288;
    assign q     = sum[39:20];

    // saturate to 16 bits signed
    always_comb
    begin
        if (q > 20'sd32767)
            q_sat = 16'sh7fff;
        else if (q < -20'sd32768)
            q_sat = 16'sh8000;
        else
            q_sat = q[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= row_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= q_sat;
    end

    assign out_valid = done_reg;
    assign out_value = value_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/log_grid_bilinear_lookup_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_grid_bilinear_lookup_top
// Bilinear lookup of log opacity in a table over log density and log
// temperature, with single-entry table writes.
// ----------------------------------------------------------------------------
//
// channel   ports                                          transfer when
// -------   ---------------------------------------------  -------------------
// command   start, busy, opcode, log_density,              start && !busy
//           log_temperature, entry_address, entry_value
// result    done, log_opacity                              done
//
// One item enters every cycle; busy stays low. A lookup passes the input
// register, grid split, table read, row blend and column blend, then raises
// done, and the result is taken while done is high. A write lands in the
// table at the read stage, so later lookups see it and earlier ones do not.
// Reset clears the valid bits and the grid stage; the table keeps no reset
// and reads garbage until written.
// The result side has no back pressure, so the pipeline never stalls.
//
module log_grid_bilinear_lookup_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                opcode,
    input  wire logic signed [15:0]  log_density,
    input  wire logic signed [15:0]  log_temperature,
    input  wire logic [9:0]          entry_address,
    input  wire logic signed [15:0]  entry_value,
    output logic                     done,
    output logic signed [15:0]       log_opacity
);

    logic                   in_valid_reg;
    logbl_pkg::opcode_t     op_reg;
    logic signed [15:0]     log_density_reg;
    logic signed [15:0]     log_temperature_reg;
    logbl_pkg::addr_t       entry_address_reg;
    logbl_pkg::data_t       entry_value_reg;

    logbl_pkg::grid_t       grid;
    logbl_pkg::corners_t    corners;

    logic                   rd_valid_reg;
    logbl_pkg::frac_t       rd_fr_reg;
    logbl_pkg::frac_t       rd_ft_reg;

    logic                   accept;

    // the pipeline always takes a new item
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        op_reg              <= logbl_pkg::opcode_t'(opcode);
        log_density_reg     <= log_density;
        log_temperature_reg <= log_temperature;
        entry_address_reg   <= entry_address;
        entry_value_reg     <= entry_value;
    end

    // grid split stage
    logbl_grid u_grid (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid_reg),
        .in_op              (op_reg),
        .in_log_density     (log_density_reg),
        .in_log_temperature (log_temperature_reg),
        .in_entry_address   (entry_address_reg),
        .in_entry_value     (entry_value_reg),
        .grid               (grid)
    );

    // table read and write stage
    logbl_table u_table (
        .clk     (clk),
        .grid    (grid),
        .corners (corners)
    );

    // fractions and lookup valid travel beside the table read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= grid.valid && (grid.op == logbl_pkg::OP_LOOKUP);
    end

    always_ff @(posedge clk)
    begin
        rd_fr_reg <= grid.fr;
        rd_ft_reg <= grid.ft;
    end

    // row and column blend stages
    logbl_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .in_fr     (rd_fr_reg),
        .in_ft     (rd_ft_reg),
        .corners   (corners),
        .out_valid (done),
        .out_value (log_opacity)
    );

    // a result comes only from a lookup transferred earlier on the command port
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && (opcode == logbl_pkg::OP_LOOKUP), 5))
        else $error("result without a matching lookup");

    // a write never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == logbl_pkg::OP_WRITE)) |-> ##5 !done)
        else $error("result produced by a table write");

    // a lookup in the read stage comes from a valid lookup in the grid stage
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(grid.valid && (grid.op == logbl_pkg::OP_LOOKUP)))
        else $error("read stage valid without a lookup");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the log grid bilinear lookup. Table writes and
// lookups go in through the command port with random gaps; a scoreboard
// keeps its own copy of the opacity table, predicts every interpolated
// result in order and compares it with each done strobe.
// ----------------------------------------------------------------------------
module tb;

    // grid geometry and arithmetic of the lookup, in Q.10
    localparam int GRID_RHO         = 32;
    localparam int GRID_TEMP        = 32;
    localparam int GRID_ENTRIES     = 1024;
    localparam int FRAC_ONE         = 1024;
    localparam int DENS_ORIGIN      = 16 * 1024;
    localparam int TEMP_ORIGIN      = 18 * 1024;
    localparam int TEMP_STEPS       = 10;

    // run length and limits
    localparam int ITEM_COUNT       = 1150;
    localparam int TAIL_CYCLES      = 12;
    localparam int WATCHDOG_LIMIT   = 2000;

    // reference copy of the table and the results still owed by the block
    class opacity_tracker;
        logic signed [15:0] entries [GRID_ENTRIES];
        logic signed [15:0] pending_opacity [$];
        int lookups;
        int writes;
        int clamped;
        int checked;
        int mismatches;

        function int pending();
            return pending_opacity.size();
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // clamped floor index and fraction of one axis
        function void grid_split(input longint pos, input int points, output int idx,
                                 output int frac, output bit clamp);
            clamp = 1'b1;
            frac  = 0;
            if (pos < 0)
                idx = 0;
            else if ((pos >>> 10) > longint'(points - 1))
                idx = points - 1;
            else
            begin
                idx   = int'(pos >>> 10);
                frac  = int'(pos & (FRAC_ONE - 1));
                clamp = 1'b0;
            end
        endfunction

        function longint entry_at(int t, int r);
            return longint'(entries[(t * GRID_RHO + r) & (GRID_ENTRIES - 1)]);
        endfunction

        // one row blended along density, scaled by 2^10
        function longint row_blend(int t, int r, int fr);
            longint v;
            longint w;
            v = entry_at(t, r);
            w = (r < GRID_RHO - 1) ? entry_at(t, r + 1) : v;
            return v * FRAC_ONE + longint'(fr) * (w - v);
        endfunction

        function logic signed [15:0] interpolate_opacity(logic signed [15:0] dens,
                                                         logic signed [15:0] temp);
            int r;
            int fr;
            int t;
            int ft;
            bit clamp_r;
            bit clamp_t;
            longint lo;
            longint hi;
            longint sum;
            longint q;
            grid_split(longint'(dens) + DENS_ORIGIN, GRID_RHO, r, fr, clamp_r);
            grid_split(longint'(temp) * TEMP_STEPS - TEMP_ORIGIN, GRID_TEMP, t, ft, clamp_t);
            if (clamp_r || clamp_t)
                clamped++;
            lo  = row_blend(t, r, fr);
            hi  = (t < GRID_TEMP - 1) ? row_blend(t + 1, r, fr) : lo;
            // round half up at 2^20, then saturate
            sum = lo * FRAC_ONE + longint'(ft) * (hi - lo) + (longint'(1) << 19);
            q   = sum >>> 20;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[15:0];
        endfunction

        function void note_transfer(logbl_pkg::opcode_t op, logic signed [15:0] dens,
                                    logic signed [15:0] temp, logic [9:0] addr,
                                    logic signed [15:0] value);
            if (op == logbl_pkg::OP_WRITE)
            begin
                entries[addr] = value;
                writes++;
            end
            else
            begin
                pending_opacity.push_back(interpolate_opacity(dens, temp));
                lookups++;
            end
        endfunction

        task check_result(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending_opacity.size() == 0)
                report($sformatf("result %0d with no lookup outstanding", got));
            else
            begin
                want = pending_opacity.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("log_opacity got %0d want %0d", got, want));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n           = 1'b0;
    logic                start           = 1'b0;
    logic                opcode          = logbl_pkg::OP_LOOKUP;
    logic signed [15:0]  log_density     = '0;
    logic signed [15:0]  log_temperature = '0;
    logic [9:0]          entry_address   = '0;
    logic signed [15:0]  entry_value     = '0;
    wire                 busy;
    wire                 done;
    wire signed [15:0]   log_opacity;

    opacity_tracker sb = new();
    bit table_loaded [GRID_ENTRIES];
    int items_sent;
    int idle_level;
    int stall_cycles;

    log_grid_bilinear_lookup_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .log_density     (log_density),
        .log_temperature (log_temperature),
        .entry_address   (entry_address),
        .entry_value     (entry_value),
        .done            (done),
        .log_opacity     (log_opacity)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // record every command transfer and check every result strobe
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(log_opacity);
            if (start && !busy)
                sb.note_transfer(logbl_pkg::opcode_t'(opcode), log_density,
                                 log_temperature, entry_address, entry_value);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // gap after a transfer, by idle level: none, light, heavy
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (idle_level == 0)
            return 0;
        if (idle_level == 1)
        begin
            if (roll < 75)
                return 0;
            if (roll < 97)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    // one command transfer, then an optional gap
    task automatic send_item(logbl_pkg::opcode_t op, logic signed [15:0] dens,
                             logic signed [15:0] temp, logic [9:0] addr,
                             logic signed [15:0] value);
        int gap;
        start           <= 1'b1;
        opcode          <= op;
        log_density     <= dens;
        log_temperature <= temp;
        entry_address   <= addr;
        entry_value     <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (op == logbl_pkg::OP_WRITE)
            table_loaded[addr] = 1'b1;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_entry(logic [9:0] addr, logic signed [15:0] value);
        send_item(logbl_pkg::OP_WRITE, 16'($urandom), 16'($urandom), addr, value);
    endtask

    // load any of the four corners a lookup reads that were never written
    task automatic load_corners(logic signed [15:0] dens, logic signed [15:0] temp);
        int r;
        int fr;
        int t;
        int ft;
        int r1;
        int t1;
        bit clamp;
        logic [9:0] corner [4];
        sb.grid_split(longint'(dens) + DENS_ORIGIN, GRID_RHO, r, fr, clamp);
        sb.grid_split(longint'(temp) * TEMP_STEPS - TEMP_ORIGIN, GRID_TEMP, t, ft, clamp);
        r1 = (r < GRID_RHO - 1) ? r + 1 : r;
        t1 = (t < GRID_TEMP - 1) ? t + 1 : t;
        corner[0] = 10'(t * GRID_RHO + r);
        corner[1] = 10'(t * GRID_RHO + r1);
        corner[2] = 10'(t1 * GRID_RHO + r);
        corner[3] = 10'(t1 * GRID_RHO + r1);
        foreach (corner[i])
            if (!table_loaded[corner[i]])
                write_entry(corner[i], 16'($urandom));
    endtask

    task automatic lookup(logic signed [15:0] dens, logic signed [15:0] temp);
        load_corners(dens, temp);
        send_item(logbl_pkg::OP_LOOKUP, dens, temp, 10'($urandom), 16'($urandom));
    endtask

    // hold off new commands until every result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // density: mostly on the grid, some near its edges, some anywhere
    function automatic logic signed [15:0] rand_density();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 16'(-16384 + int'($urandom_range(0, 32767)));
        if (roll < 85)
            return ($urandom_range(0, 1) != 0) ? 16'(-16392 + int'($urandom_range(0, 16)))
                                               : 16'(16376 + int'($urandom_range(0, 16)));
        return 16'($urandom);
    endfunction

    // temperature: grid spans 1844..5119 in Q5.10
    function automatic logic signed [15:0] rand_temperature();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 16'(1843 + int'($urandom_range(0, 3277)));
        if (roll < 85)
            return ($urandom_range(0, 1) != 0) ? 16'(1836 + int'($urandom_range(0, 16)))
                                               : 16'(5010 + int'($urandom_range(0, 120)));
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial
    begin
        bit paused;
        paused     = 1'b0;
        idle_level = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ties, clamps on both sides, last row and column, extremes
        write_entry(10'd0, 16'sd0);
        write_entry(10'd1, -16'sd1);
        write_entry(10'd64, 16'sd0);
        write_entry(10'd65, 16'sd1);
        write_entry(10'd1022, 16'sh8000);
        write_entry(10'd1023, 16'sh7FFF);
        lookup(16'sh8000, 16'sh8000);            // below the grid on both axes
        lookup(16'(-16384 + 512), 16'sd1843);    // slightly below temperature, half tie down
        lookup(16'(-16384 + 512), 16'sd2048);    // exact temperature point, half tie up
        lookup(16'sd16383, 16'sd5018);           // last column and last row repeat
        lookup(16'sd15359, 16'sd5119);           // full-scale blend of the extremes
        lookup(16'sh7FFF, 16'sh7FFF);            // above the grid on both axes
        lookup(-16'sd16385, 16'sd2048);          // density just below the first point
        lookup(16'sd1023, 16'sd3000);            // mid grid, largest density fraction
        lookup(16'sd20000, 16'sd3000);           // above on density only

        // random: mixed writes and lookups in bursts of varying idle level
        while (items_sent < ITEM_COUNT)
        begin
            if ((items_sent % 64) == 0)
                idle_level = $urandom_range(0, 2);
            if (!paused && items_sent >= ITEM_COUNT / 2)
            begin
                paused = 1'b1;
                wait_for_results();
            end
            if ($urandom_range(0, 99) < 20)
                write_entry(10'($urandom), rand_entry());
            else
                lookup(rand_density(), rand_temperature());
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d lookups (%0d clamped on an axis) and %0d table writes",
                 sb.lookups, sb.clamped, sb.writes);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/logbl_pkg.sv
hw/rtl/logbl_grid.sv
hw/rtl/logbl_table.sv
hw/rtl/logbl_blend.sv
hw/rtl/log_grid_bilinear_lookup_top.sv
tb/tb.sv
